### rtl/swmm_pkg.sv
// Shared constants and control types for the sliding window min/max/sum block.
package swmm_pkg;

    // Configuration register and APB port geometry.
    localparam int CFG_W  = 7;
    localparam int APB_AW = 2;
    localparam int APB_DW = 32;

    // Running total width (wraps).
    localparam int SUM_W = 64;

    // Register map.
    localparam logic [APB_AW-1:0] ADDR_WINDOW_SIZE = 2'd0;

    localparam logic [CFG_W-1:0] WINDOW_RESET = 7'd1;

    // Top level to queue: one word accepted, and whether it ends the sequence.
    typedef struct packed {
        logic step;
        logic clear;
    } t_q_cmd;

    // Queue to each cell: broadcast control for the cycle.
    typedef struct packed {
        logic step;   // insert the new sample, pop dominated entries
        logic shift;  // front entry leaves, everything moves one cell left
        logic clear;  // sequence ended, drop all entries
    } t_cell_ctl;

endpackage

### rtl/swmm_cell.sv
// One queue cell: holds a (value, position) entry and trades it with its neighbors.
module swmm_cell
    import swmm_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int POS_W        = 7,
    parameter bit IS_MAX       = 1'b1,
    parameter bit IS_FRONT     = 1'b0
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_cell_ctl                      i_ctl,
    input  logic signed [SAMPLE_WIDTH-1:0] i_x,
    input  logic        [POS_W-1:0]        i_pos,
    input  logic                           i_left_ok,
    input  logic                           i_right_keep,
    input  logic signed [SAMPLE_WIDTH-1:0] i_right_value,
    input  logic        [POS_W-1:0]        i_right_pos,
    output logic                           o_keep,
    output logic                           o_left_ok,
    output logic                           o_valid,
    output logic signed [SAMPLE_WIDTH-1:0] o_value,
    output logic        [POS_W-1:0]        o_pos,
    output logic signed [SAMPLE_WIDTH-1:0] o_next_value
);

    logic                           r_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_value;
    logic        [POS_W-1:0]        r_pos;
    logic                           n_valid;
    logic signed [SAMPLE_WIDTH-1:0] n_value;
    logic        [POS_W-1:0]        n_pos;

    logic                           dominated;
    logic                           pop;
    logic                           src_keep;
    logic signed [SAMPLE_WIDTH-1:0] src_value;
    logic        [POS_W-1:0]        src_pos;
    logic                           ins_ok;

    // Ties pop too: the newer sample replaces an equal one.
    assign dominated = IS_MAX ? (r_value <= i_x) : (i_x <= r_value);
    assign pop       = i_ctl.step & r_valid & dominated;
    assign o_keep    = r_valid & ~pop & ~(IS_FRONT & i_ctl.shift);
    // An expired front acts as the left edge of the survivors.
    assign o_left_ok = o_keep | (IS_FRONT & i_ctl.shift);

    assign src_keep  = i_ctl.shift ? i_right_keep  : o_keep;
    assign src_value = i_ctl.shift ? i_right_value : r_value;
    assign src_pos   = i_ctl.shift ? i_right_pos   : r_pos;
    assign ins_ok    = i_ctl.shift ? o_left_ok     : i_left_ok;

    always_comb begin
        n_valid = 1'b0;
        n_value = r_value;
        n_pos   = r_pos;
        if (src_keep) begin
            n_valid = 1'b1;
            n_value = src_value;
            n_pos   = src_pos;
        end else if (i_ctl.step && ins_ok) begin
            n_valid = 1'b1;
            n_value = i_x;
            n_pos   = i_pos;
        end
        if (i_ctl.clear) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_pos   <= n_pos;
    end

    assign o_valid      = r_valid;
    assign o_value      = r_value;
    assign o_pos        = r_pos;
    assign o_next_value = n_value;

endmodule

### rtl/swmm_queue.sv
// Monotonic queue built as a chain of cells, front at cell 0.
module swmm_queue
    import swmm_pkg::*;
#(
    parameter int MAX_WINDOW   = 64,
    parameter int SAMPLE_WIDTH = 16,
    parameter bit IS_MAX       = 1'b1
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  t_q_cmd                                   i_cmd,
    input  logic signed [SAMPLE_WIDTH-1:0]           i_x,
    input  logic [$clog2(2*MAX_WINDOW)-1:0]          i_pos,
    input  logic [CFG_W-1:0]                         i_window,
    output logic                                     o_stale,
    output logic                                     o_front_valid,
    output logic signed [SAMPLE_WIDTH-1:0]           o_front_next
);

    localparam int POS_W   = $clog2(2*MAX_WINDOW);
    localparam int POS_MOD = 2*MAX_WINDOW;
    localparam int AW      = ((POS_W + 1) > CFG_W) ? (POS_W + 1) : CFG_W;

    logic                           w_keep      [MAX_WINDOW];
    logic                           w_lk        [MAX_WINDOW];
    logic signed [SAMPLE_WIDTH-1:0] w_value     [MAX_WINDOW];
    logic        [POS_W-1:0]        w_pos       [MAX_WINDOW];
    logic                           w_left_ok   [MAX_WINDOW];
    logic                           w_rkeep     [MAX_WINDOW];
    logic signed [SAMPLE_WIDTH-1:0] w_rvalue    [MAX_WINDOW];
    logic        [POS_W-1:0]        w_rpos      [MAX_WINDOW];

    logic [AW-1:0] age;
    logic [AW-1:0] win;
    logic          expire;
    t_cell_ctl     ctl;

    // Age of the front entry, modulo the position count.
    always_comb begin
        if (i_pos >= w_pos[0]) begin
            age = AW'(i_pos) - AW'(w_pos[0]);
        end else begin
            age = AW'(i_pos) + AW'(POS_MOD) - AW'(w_pos[0]);
        end
    end

    assign win     = AW'(i_window);
    assign expire  = o_front_valid & (age >= win);
    // More than one entry would expire: drain the front first.
    assign o_stale = o_front_valid & (age > win);

    assign ctl.step  = i_cmd.step;
    assign ctl.clear = i_cmd.clear;
    assign ctl.shift = i_cmd.step ? expire : o_stale;

    for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
        if (k == 0) begin : g_left_edge
            assign w_left_ok[k] = 1'b1;
        end else begin : g_left
            assign w_left_ok[k] = w_lk[k-1];
        end

        if (k == MAX_WINDOW - 1) begin : g_right_edge
            assign w_rkeep[k]  = 1'b0;
            assign w_rvalue[k] = '0;
            assign w_rpos[k]   = '0;
        end else begin : g_right
            assign w_rkeep[k]  = w_keep[k+1];
            assign w_rvalue[k] = w_value[k+1];
            assign w_rpos[k]   = w_pos[k+1];
        end

        if (k == 0) begin : g_front
            swmm_cell #(
                .SAMPLE_WIDTH (SAMPLE_WIDTH),
                .POS_W        (POS_W),
                .IS_MAX       (IS_MAX),
                .IS_FRONT     (1'b1)
            ) u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctl         (ctl),
                .i_x           (i_x),
                .i_pos         (i_pos),
                .i_left_ok     (w_left_ok[k]),
                .i_right_keep  (w_rkeep[k]),
                .i_right_value (w_rvalue[k]),
                .i_right_pos   (w_rpos[k]),
                .o_keep        (w_keep[k]),
                .o_left_ok     (w_lk[k]),
                .o_valid       (o_front_valid),
                .o_value       (w_value[k]),
                .o_pos         (w_pos[k]),
                .o_next_value  (o_front_next)
            );
        end else begin : g_body
            swmm_cell #(
                .SAMPLE_WIDTH (SAMPLE_WIDTH),
                .POS_W        (POS_W),
                .IS_MAX       (IS_MAX),
                .IS_FRONT     (1'b0)
            ) u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctl         (ctl),
                .i_x           (i_x),
                .i_pos         (i_pos),
                .i_left_ok     (w_left_ok[k]),
                .i_right_keep  (w_rkeep[k]),
                .i_right_value (w_rvalue[k]),
                .i_right_pos   (w_rpos[k]),
                .o_keep        (w_keep[k]),
                .o_left_ok     (w_lk[k]),
                .o_valid       (),
                .o_value       (w_value[k]),
                .o_pos         (w_pos[k]),
                .o_next_value  ()
            );
        end
    end

endmodule

### rtl/sliding_window_min_max_sum.sv
// Sliding window min/max tracker with running (max + min) total, top level.
//
// Takes one signed sample word per cycle while o_ready is high and returns
// one result word per sample: the max and min over the last window_size
// samples of the current sequence, a full flag once window_size samples have
// been seen, and a 64-bit wrapping total of max + min over all full windows.
// A sample with last set ends the sequence; every piece of state except
// window_size clears after it. Two monotonic queues (one for max, one for
// min) are each a chain of MAX_WINDOW cells with the queue front in cell 0;
// each cycle every cell looks only at its neighbors to pop dominated
// entries, append the new sample and drop an expired front. Throughput is
// one sample per clock while no queue front drains and the output is not
// held back. A sample passes the queue update into the mid register, then
// the 64-bit accumulate into the output register. Only the front cell can
// expire per sample, so after window_size is lowered mid-sequence each queue
// drops one stale front per cycle and the input stalls until at most one
// entry, the one the next sample expires itself, lies outside the new
// window. window_size of 0 acts as 1 and values above MAX_WINDOW act as
// MAX_WINDOW; the register itself reads back as written.
// APB: window_size at byte address 0, pready is tied high.
module sliding_window_min_max_sum
    import swmm_pkg::*;
#(
    parameter int MAX_WINDOW   = 64,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // sample stream in
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  logic                           i_last,
    // result stream out
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_window_full,
    output logic signed [SAMPLE_WIDTH-1:0] o_window_max,
    output logic signed [SAMPLE_WIDTH-1:0] o_window_min,
    output logic signed [SUM_W-1:0]        o_running_sum,
    output logic                           o_sequence_end,
    // config port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [APB_AW-1:0]              paddr,
    input  logic [APB_DW-1:0]              pwdata,
    output logic [APB_DW-1:0]              prdata,
    output logic                           pready
);

    localparam int POS_W   = $clog2(2*MAX_WINDOW);
    localparam int WMAX    = (MAX_WINDOW < 127) ? MAX_WINDOW : 127;
    localparam logic [CFG_W-1:0] WMAX_V   = CFG_W'(WMAX);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(2*MAX_WINDOW - 1);

    // ---------------- config register ----------------
    logic [CFG_W-1:0] r_window;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready & (paddr == ADDR_WINDOW_SIZE);
    assign prdata = (paddr == ADDR_WINDOW_SIZE) ? APB_DW'(r_window) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RESET;
        end else if (cfg_wr) begin
            r_window <= pwdata[CFG_W-1:0];
        end
    end

    // Effective window: zero acts as one, clamp at MAX_WINDOW.
    logic [CFG_W-1:0] w_eff;
    always_comb begin
        if (r_window == '0) begin
            w_eff = CFG_W'(1);
        end else if (r_window > WMAX_V) begin
            w_eff = WMAX_V;
        end else begin
            w_eff = r_window;
        end
    end

    // ---------------- stage A: queue update ----------------
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic [CFG_W-1:0] r_seen;
    logic [CFG_W-1:0] n_seen;
    logic [CFG_W:0]   seen_inc;
    logic [CFG_W-1:0] seen_step;
    logic             acc;
    logic             stale_max;
    logic             stale_min;
    logic             max_front_valid;
    logic             min_front_valid;
    logic signed [SAMPLE_WIDTH-1:0] max_next;
    logic signed [SAMPLE_WIDTH-1:0] min_next;
    t_q_cmd           qcmd;

    logic             mid_adv;
    logic             r_mid_valid;

    assign o_ready = ~(stale_max | stale_min) & (~r_mid_valid | mid_adv);
    assign acc     = i_valid & o_ready;

    assign qcmd.step  = acc;
    assign qcmd.clear = acc & i_last;

    swmm_queue #(
        .MAX_WINDOW   (MAX_WINDOW),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .IS_MAX       (1'b1)
    ) u_max_q (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (qcmd),
        .i_x           (i_sample),
        .i_pos         (r_pos),
        .i_window      (w_eff),
        .o_stale       (stale_max),
        .o_front_valid (max_front_valid),
        .o_front_next  (max_next)
    );

    swmm_queue #(
        .MAX_WINDOW   (MAX_WINDOW),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .IS_MAX       (1'b0)
    ) u_min_q (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (qcmd),
        .i_x           (i_sample),
        .i_pos         (r_pos),
        .i_window      (w_eff),
        .o_stale       (stale_min),
        .o_front_valid (min_front_valid),
        .o_front_next  (min_next)
    );

    // seen saturates at the effective window size
    assign seen_inc  = {1'b0, r_seen} + (CFG_W+1)'(1);
    assign seen_step = (seen_inc < {1'b0, w_eff}) ? seen_inc[CFG_W-1:0] : w_eff;

    always_comb begin
        n_pos  = r_pos;
        n_seen = r_seen;
        if (acc) begin
            if (i_last) begin
                n_pos  = '0;
                n_seen = '0;
            end else begin
                n_pos  = (r_pos == POS_LAST) ? '0 : r_pos + POS_W'(1);
                n_seen = seen_step;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_seen <= '0;
        end else begin
            r_pos  <= n_pos;
            r_seen <= n_seen;
        end
    end

    // ---------------- mid register ----------------
    logic                           r_mid_full;
    logic                           r_mid_last;
    logic signed [SAMPLE_WIDTH-1:0] r_mid_max;
    logic signed [SAMPLE_WIDTH-1:0] r_mid_min;
    logic                           n_mid_valid;
    logic                           r_out_valid;

    assign mid_adv = r_mid_valid & (~r_out_valid | i_ready);

    always_comb begin
        n_mid_valid = r_mid_valid;
        if (acc) begin
            n_mid_valid = 1'b1;
        end else if (mid_adv) begin
            n_mid_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_valid <= 1'b0;
        end else begin
            r_mid_valid <= n_mid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_mid_full <= (seen_step == w_eff);
            r_mid_last <= i_last;
            r_mid_max  <= max_next;
            r_mid_min  <= min_next;
        end
    end

    // ---------------- stage B: accumulate, output register ----------------
    logic signed [SUM_W-1:0] r_total;
    logic signed [SUM_W-1:0] n_total;
    logic signed [SUM_W-1:0] pair_sum;
    logic signed [SUM_W-1:0] sum_now;
    logic                    n_out_valid;
    logic                    r_out_full;
    logic                    r_out_last;
    logic signed [SAMPLE_WIDTH-1:0] r_out_max;
    logic signed [SAMPLE_WIDTH-1:0] r_out_min;
    logic signed [SUM_W-1:0] r_out_sum;

    assign pair_sum = SUM_W'(r_mid_max) + SUM_W'(r_mid_min);
    assign sum_now  = r_mid_full ? (r_total + pair_sum) : r_total;

    always_comb begin
        n_total     = r_total;
        n_out_valid = r_out_valid;
        if (mid_adv) begin
            n_total     = r_mid_last ? '0 : sum_now;
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mid_adv) begin
            r_out_full <= r_mid_full;
            r_out_last <= r_mid_last;
            r_out_max  <= r_mid_max;
            r_out_min  <= r_mid_min;
            r_out_sum  <= sum_now;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_window_full  = r_out_full;
    assign o_window_max   = r_out_max;
    assign o_window_min   = r_out_min;
    assign o_running_sum  = r_out_sum;
    assign o_sequence_end = r_out_last;

`ifndef ASSERT_OFF
    // Both queues span the same live samples, so max never falls below min.
    a_max_ge_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_window_max >= o_window_min))
        else $error("window max below window min");

    // The word marked last leaves the sequence counters cleared.
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_last) |=> (r_seen == '0 && r_pos == '0 && !max_front_valid))
        else $error("sequence state not cleared after last");

    // Any other accepted word leaves a front entry in both queues.
    a_front_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && !i_last) |=> (max_front_valid && min_front_valid))
        else $error("queue front empty after insert");

    // The input stalls while a queue front is draining.
    a_stall_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stale_max || stale_min) |-> !acc)
        else $error("word accepted while queue front drains");
`endif

endmodule
